// ===== rtl/hpt_pkg.sv =====
// Shared types and constants for the histogram percentile threshold filter.
// No dependencies; used by hpt_scan and histogram_percentile_threshold_filter_top.
package hpt_pkg;

    localparam int VALUE_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF = 24;

    localparam int FIELD_W    = 8;
    localparam int PCT_W      = 7;
    localparam int MIN_W      = 10;
    localparam int LIM_W      = MIN_W - 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MIN_W;

    localparam logic [PCT_W-1:0] PCT_SCALE   = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_RESET   = PCT_W'(100);
    localparam logic [MIN_W-1:0] MIN_RESET   = MIN_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_PERCENTAGE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE  = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_PREP,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [FIELD_W-1:0] thresh;
    } scan_status_t;

endpackage

// ===== rtl/hpt_scan.sv =====
// Percentile scan over the histogram bins, pipelined behind the bin memory read port.
// Depends on hpt_pkg; the bin memory itself lives in the top level.
module hpt_scan #(
    parameter int VALUE_BITS = hpt_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = hpt_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        scan_start,
    input  logic [hpt_pkg::PCT_W-1:0]   pct,
    input  logic [hpt_pkg::MIN_W-1:0]   min_value,
    input  logic [COUNT_BITS-1:0]       total,
    input  logic [VALUE_BITS-1:0]       max_bin,
    input  logic [COUNT_BITS-1:0]       rd_data,
    output logic                        rd_en,
    output logic [VALUE_BITS-1:0]       rd_addr,
    output hpt_pkg::scan_status_t       status
);
    import hpt_pkg::*;

    localparam int CNT_AW = VALUE_BITS + 1;
    localparam int TGT_W  = COUNT_BITS + PCT_W;
    localparam int C100_W = COUNT_BITS + PCT_W;
    localparam int ACC_W  = COUNT_BITS + VALUE_BITS + PCT_W;
    localparam int CMP_W  = ((VALUE_BITS > LIM_W) ? VALUE_BITS : LIM_W) + 1;

    logic                  active_reg;
    logic [CNT_AW-1:0]     addr_reg;
    logic [TGT_W-1:0]      target_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic                  p1_vld_reg;
    logic [VALUE_BITS-1:0] p1_bin_reg;
    logic                  p2_vld_reg;
    logic [VALUE_BITS-1:0] p2_bin_reg;
    logic                  p2_nz_reg;
    logic [C100_W-1:0]     c100_reg;

    logic [PCT_W-1:0]      pct_clamp;
    logic [C100_W-1:0]     c100_next;
    logic                  lim_stop;
    logic                  hit;
    logic                  finish;

    assign pct_clamp = (pct > PCT_SCALE) ? PCT_SCALE : pct;
    assign rd_en     = active_reg && !addr_reg[VALUE_BITS];
    assign rd_addr   = addr_reg[VALUE_BITS-1:0];
    assign c100_next = (C100_W'(rd_data) << 6) + (C100_W'(rd_data) << 5)
                     + (C100_W'(rd_data) << 2);

    // A negative limit stops at the largest depth present.
    assign lim_stop = min_value[MIN_W-1] ? (p2_bin_reg >= max_bin)
                    : (CMP_W'(p2_bin_reg) >= CMP_W'(min_value[LIM_W-1:0]));
    assign hit      = p2_vld_reg && p2_nz_reg
                   && ((acc_reg >= ACC_W'(target_reg)) || lim_stop);
    assign finish   = active_reg
                   && (hit || (addr_reg[VALUE_BITS] && !p1_vld_reg && !p2_vld_reg));

    assign status.done   = finish;
    assign status.found  = hit;
    assign status.thresh = FIELD_W'(p2_bin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else if (scan_start)
        begin
            active_reg <= 1'b1;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else if (finish)
        begin
            active_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= rd_en;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            addr_reg   <= '0;
            acc_reg    <= '0;
            target_reg <= TGT_W'(pct_clamp) * TGT_W'(total);
        end
        else
        begin
            if (rd_en)
            begin
                addr_reg <= addr_reg + CNT_AW'(1);
            end
            if (p2_vld_reg && p2_nz_reg && !hit)
            begin
                acc_reg <= acc_reg + ACC_W'(c100_reg);
            end
        end
        p1_bin_reg <= rd_addr;
        p2_bin_reg <= p1_bin_reg;
        p2_nz_reg  <= (rd_data != '0);
        c100_reg   <= c100_next;
    end

endmodule

// ===== rtl/histogram_percentile_threshold_filter_top.sv =====
// Top level of the histogram percentile threshold filter: control, bin memory, config.
// Depends on hpt_pkg and hpt_scan.
//
//  channel   handshake                 word
//  input     start / busy              kind, skel_value, depth_value, last
//  result    out_valid (strobe)        skel_out, reject_out, threshold, no_selection, last_out
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A histogram word with a nonzero skeleton value takes a memory read, then a write.
// A filter result is registered and appears in the cycle after its word is taken.
// The last histogram word is followed by a scan through the
// bin memory read port; the last filter word starts a clear of the bin memory.
// After reset the bin memory is cleared while busy is high.
// Results are never held back; config writes are taken in every cycle.
module histogram_percentile_threshold_filter_top #(
    parameter int VALUE_BITS = hpt_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = hpt_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [hpt_pkg::FIELD_W-1:0]     skel_value,
    input  logic [hpt_pkg::FIELD_W-1:0]     depth_value,
    input  logic                            last,
    output logic                            out_valid,
    output logic [hpt_pkg::FIELD_W-1:0]     skel_out,
    output logic [hpt_pkg::FIELD_W-1:0]     reject_out,
    output logic [hpt_pkg::FIELD_W-1:0]     threshold,
    output logic                            no_selection,
    output logic                            last_out,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hpt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hpt_pkg::*;

    localparam int NUM_BINS = 1 << VALUE_BITS;

    state_t                state_reg, state_next;
    logic [PCT_W-1:0]      pct_reg;
    logic [MIN_W-1:0]      min_reg;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [VALUE_BITS-1:0] maxv_reg, maxv_next;
    logic                  any_reg, any_next;
    logic [VALUE_BITS-1:0] inc_addr_reg, inc_addr_next;
    logic                  hist_last_reg, hist_last_next;
    logic [VALUE_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [FIELD_W-1:0]    thr_reg, thr_next;
    logic                  nosel_reg, nosel_next;

    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]    out_skel_reg, out_skel_next;
    logic [FIELD_W-1:0]    out_rej_reg, out_rej_next;
    logic [FIELD_W-1:0]    out_thr_reg, out_thr_next;
    logic                  out_nosel_reg, out_nosel_next;
    logic                  out_last_reg, out_last_next;

    logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  mem_re;
    logic [VALUE_BITS-1:0] mem_raddr;
    logic                  mem_we;
    logic [VALUE_BITS-1:0] mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic                  accept;
    logic                  scan_start;
    logic                  scan_rd_en;
    logic [VALUE_BITS-1:0] scan_rd_addr;
    scan_status_t          scan_st;
    logic [VALUE_BITS-1:0] depth_bin;
    logic                  keep;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign depth_bin = VALUE_BITS'(depth_value);
    assign keep      = (skel_value != '0) && (depth_value >= thr_reg);

    assign out_valid    = out_valid_reg;
    assign skel_out     = out_skel_reg;
    assign reject_out   = out_rej_reg;
    assign threshold    = out_thr_reg;
    assign no_selection = out_nosel_reg;
    assign last_out     = out_last_reg;

    hpt_scan #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_start (scan_start),
        .pct        (pct_reg),
        .min_value  (min_reg),
        .total      (total_reg),
        .max_bin    (maxv_reg),
        .rd_data    (rd_data_reg),
        .rd_en      (scan_rd_en),
        .rd_addr    (scan_rd_addr),
        .status     (scan_st)
    );

    assign mem_re    = (accept && !kind && (skel_value != '0)) || scan_rd_en;
    assign mem_raddr = scan_rd_en ? scan_rd_addr : depth_bin;
    assign mem_we    = (state_reg == ST_INC) || (state_reg == ST_CLEAR);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : inc_addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0
                     : ((rd_data_reg == '1) ? rd_data_reg
                                            : rd_data_reg + COUNT_BITS'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= bin_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg <= PCT_RESET;
            min_reg <= MIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PERCENTAGE: pct_reg <= cfg_data[PCT_W-1:0];
                CFG_MIN_VALUE:  min_reg <= cfg_data[MIN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            total_reg     <= '0;
            maxv_reg      <= '0;
            any_reg       <= 1'b0;
            hist_last_reg <= 1'b0;
            clr_addr_reg  <= '0;
            thr_reg       <= '0;
            nosel_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            maxv_reg      <= maxv_next;
            any_reg       <= any_next;
            hist_last_reg <= hist_last_next;
            clr_addr_reg  <= clr_addr_next;
            thr_reg       <= thr_next;
            nosel_reg     <= nosel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_addr_reg  <= inc_addr_next;
        out_skel_reg  <= out_skel_next;
        out_rej_reg   <= out_rej_next;
        out_thr_reg   <= out_thr_next;
        out_nosel_reg <= out_nosel_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        maxv_next      = maxv_reg;
        any_next       = any_reg;
        inc_addr_next  = inc_addr_reg;
        hist_last_next = hist_last_reg;
        clr_addr_next  = clr_addr_reg;
        thr_next       = thr_reg;
        nosel_next     = nosel_reg;
        out_valid_next = 1'b0;
        out_skel_next  = out_skel_reg;
        out_rej_next   = out_rej_reg;
        out_thr_next   = out_thr_reg;
        out_nosel_next = out_nosel_reg;
        out_last_next  = out_last_reg;
        scan_start     = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + VALUE_BITS'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && !kind)
                begin
                    if (skel_value != '0)
                    begin
                        total_next     = (total_reg == '1) ? total_reg
                                                           : total_reg + COUNT_BITS'(1);
                        any_next       = 1'b1;
                        maxv_next      = (!any_reg || (depth_bin > maxv_reg)) ? depth_bin
                                                                              : maxv_reg;
                        inc_addr_next  = depth_bin;
                        hist_last_next = last;
                        state_next     = ST_INC;
                    end
                    else if (last)
                    begin
                        state_next = ST_PREP;
                    end
                end
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_skel_next  = keep ? skel_value : '0;
                    out_rej_next   = keep ? depth_value : '0;
                    out_thr_next   = thr_reg;
                    out_nosel_next = nosel_reg;
                    out_last_next  = last;
                    if (last)
                    begin
                        total_next    = '0;
                        any_next      = 1'b0;
                        maxv_next     = '0;
                        clr_addr_next = '0;
                        state_next    = ST_CLEAR;
                    end
                end
            end
            ST_INC:
            begin
                state_next = hist_last_reg ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                scan_start = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_st.done)
                begin
                    thr_next       = scan_st.found ? scan_st.thresh : '0;
                    nosel_next     = !scan_st.found;
                    out_valid_next = 1'b1;
                    out_skel_next  = '0;
                    out_rej_next   = '0;
                    out_thr_next   = scan_st.found ? scan_st.thresh : '0;
                    out_nosel_next = !scan_st.found;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_st.done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside the scan state");

    a_inc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INC) |-> ($past(state_reg) == ST_IDLE))
        else $error("bin update without a preceding histogram word");

    a_nosel_zero_thr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_nosel_reg) |-> (out_thr_reg == '0))
        else $error("threshold not zero with no selection");

    a_prep_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |=> (state_reg == ST_SCAN))
        else $error("scan did not start after preparation");

endmodule

// ===== tb/histogram_percentile_threshold_filter_top_test.sv =====
// Self-checking testbench for histogram_percentile_threshold_filter_top: directed and random
// volumes of histogram and filter passes, checked against an internal threshold predictor.
// Depends on hpt_pkg and the RTL of histogram_percentile_threshold_filter_top.
`timescale 1ns / 1ps

module histogram_percentile_threshold_filter_top_test;
    import hpt_pkg::*;

    localparam int            BINS        = 1 << VALUE_BITS_DEF;
    localparam int            COUNT_W     = COUNT_BITS_DEF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic          KIND_HIST   = 1'b0;
    localparam logic          KIND_FILTER = 1'b1;
    localparam logic [MIN_W-1:0] MIN_LARGEST = '1;
    localparam int            QUIET_CYCLES = BINS + 16;
    localparam int            STALL_LIMIT  = 4000;
    localparam int            RANDOM_WORDS = 650;

    typedef struct {
        logic               kind;
        logic [FIELD_W-1:0] skel;
        logic [FIELD_W-1:0] depth;
        logic               last;
    } voxel_word_t;

    typedef struct {
        logic [FIELD_W-1:0] skel;
        logic [FIELD_W-1:0] reject;
        logic [FIELD_W-1:0] thresh;
        logic               nosel;
        logic               last;
    } voxel_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 kind = 1'b0;
    logic [FIELD_W-1:0]   skel_value = '0;
    logic [FIELD_W-1:0]   depth_value = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic [FIELD_W-1:0]   skel_out;
    logic [FIELD_W-1:0]   reject_out;
    logic [FIELD_W-1:0]   threshold;
    logic                 no_selection;
    logic                 last_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    voxel_word_t   pending_voxels[$];
    voxel_result_t expected_results[$];
    voxel_word_t   next_voxel;

    logic [COUNT_W-1:0] bin_tally [BINS] = '{default: '0};
    logic [COUNT_W-1:0] voxel_total = '0;
    logic [FIELD_W-1:0] thresh_q = '0;
    logic               nosel_q = 1'b0;
    logic [PCT_W-1:0]   pct_cfg = PCT_RESET;
    logic [MIN_W-1:0]   minv_cfg = MIN_RESET;

    bit gaps_on = 1'b1;
    int gap_left = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int words_queued = 0;
    int words_taken = 0;
    int results_checked = 0;
    int scans_run = 0;
    int scans_empty = 0;
    int cfg_writes = 0;
    int volumes = 0;

    histogram_percentile_threshold_filter_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .skel_value   (skel_value),
        .depth_value  (depth_value),
        .last         (last),
        .out_valid    (out_valid),
        .skel_out     (skel_out),
        .reject_out   (reject_out),
        .threshold    (threshold),
        .no_selection (no_selection),
        .last_out     (last_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
                               input logic [FIELD_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s = %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic pick_threshold();
        logic [PCT_W-1:0] pct;
        logic [63:0]      target;
        logic [63:0]      running;
        int               stop_at;
        pct = (pct_cfg > PCT_SCALE) ? PCT_SCALE : pct_cfg;
        target = 64'(pct) * 64'(voxel_total);
        running = '0;
        scans_run++;
        if (minv_cfg[MIN_W-1])
        begin
            stop_at = -1;
            for (int v = 0; v < BINS; v++)
            begin
                if (bin_tally[v] != '0)
                begin
                    stop_at = v;
                end
            end
        end
        else
        begin
            stop_at = int'(minv_cfg[LIM_W-1:0]);
        end
        for (int v = 0; v < BINS; v++)
        begin
            if (bin_tally[v] != '0)
            begin
                if (running * 64'(PCT_SCALE) >= target || v >= stop_at)
                begin
                    thresh_q = FIELD_W'(v);
                    nosel_q = 1'b0;
                    return;
                end
                running += 64'(bin_tally[v]);
            end
        end
        thresh_q = '0;
        nosel_q = 1'b1;
        scans_empty++;
    endtask

    task automatic predict_voxel(input voxel_word_t w);
        voxel_result_t r;
        words_taken++;
        if (w.kind == KIND_HIST)
        begin
            if (w.skel != '0)
            begin
                if (bin_tally[w.depth] != COUNT_MAX)
                begin
                    bin_tally[w.depth]++;
                end
                if (voxel_total != COUNT_MAX)
                begin
                    voxel_total++;
                end
            end
            if (w.last)
            begin
                pick_threshold();
                r.skel = '0;
                r.reject = '0;
                r.thresh = thresh_q;
                r.nosel = nosel_q;
                r.last = 1'b1;
                expected_results.push_back(r);
            end
        end
        else
        begin
            if (w.skel != '0 && w.depth >= thresh_q)
            begin
                r.skel = w.skel;
                r.reject = w.depth;
            end
            else
            begin
                r.skel = '0;
                r.reject = '0;
            end
            r.thresh = thresh_q;
            r.nosel = nosel_q;
            r.last = w.last;
            expected_results.push_back(r);
            if (w.last)
            begin
                foreach (bin_tally[b])
                begin
                    bin_tally[b] = '0;
                end
                voxel_total = '0;
            end
        end
    endtask

    task automatic queue_voxel(input logic k, input logic [FIELD_W-1:0] s,
                               input logic [FIELD_W-1:0] d, input logic l);
        voxel_word_t w;
        w.kind = k;
        w.skel = s;
        w.depth = d;
        w.last = l;
        pending_voxels.push_back(w);
        words_queued++;
    endtask

    task automatic queue_pass(input logic pass_kind, input int center, input int mask);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
        begin
            queue_voxel(pass_kind,
                        ($urandom_range(0, 3) == 0) ? '0 : FIELD_W'($urandom_range(1, 255)),
                        FIELD_W'(center ^ $urandom_range(0, mask)),
                        i == n - 1);
        end
    endtask

    task automatic wait_quiet();
        while (pending_voxels.size() != 0 || start || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PERCENTAGE)
        begin
            pct_cfg = val[PCT_W-1:0];
        end
        else
        begin
            minv_cfg = val[MIN_W-1:0];
        end
        cfg_writes++;
    endtask

    task automatic reconfigure(input logic [PCT_W-1:0] pct, input logic [MIN_W-1:0] minv);
        wait_quiet();
        write_register(CFG_PERCENTAGE, CFG_DATA_W'(pct));
        write_register(CFG_MIN_VALUE, CFG_DATA_W'(minv));
        @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                next_voxel.kind = kind;
                next_voxel.skel = skel_value;
                next_voxel.depth = depth_value;
                next_voxel.last = last;
                predict_voxel(next_voxel);
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (gaps_on && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(0, 13);
                    start <= 1'b0;
                end
                else if (pending_voxels.size() != 0)
                begin
                    next_voxel = pending_voxels.pop_front();
                    start <= 1'b1;
                    kind <= next_voxel.kind;
                    skel_value <= next_voxel.skel;
                    depth_value <= next_voxel.depth;
                    last <= next_voxel.last;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        voxel_result_t want;
        if (rst_n && out_valid)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word skel_out=%0d threshold=%0d",
                                          skel_out, threshold));
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("skel_out", skel_out, want.skel);
                check_field("reject_out", reject_out, want.reject);
                check_field("threshold", threshold, want.thresh);
                check_field("no_selection", FIELD_W'(no_selection), FIELD_W'(want.nosel));
                check_field("last_out", FIELD_W'(last_out), FIELD_W'(want.last));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [PCT_W-1:0] pct_pick;
        logic [MIN_W-1:0] min_pick;
        int               first_random;
        int               center;
        int               mask;
        int               plan;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Defaults written explicitly; empty histogram, then a scan that runs past every bin.
        reconfigure(PCT_RESET, MIN_RESET);
        queue_voxel(KIND_HIST, 8'd0, 8'd77, 1'b1);
        queue_voxel(KIND_FILTER, 8'd255, 8'd0, 1'b0);
        queue_voxel(KIND_FILTER, 8'd0, 8'd255, 1'b1);
        queue_voxel(KIND_HIST, 8'd5, 8'd30, 1'b0);
        queue_voxel(KIND_HIST, 8'd5, 8'd31, 1'b1);
        queue_voxel(KIND_FILTER, 8'd255, 8'd29, 1'b1);

        reconfigure(PCT_W'(50), MIN_LARGEST);
        queue_voxel(KIND_HIST, 8'd1, 8'd10, 1'b0);
        queue_voxel(KIND_HIST, 8'd255, 8'd200, 1'b0);
        queue_voxel(KIND_HIST, 8'd128, 8'd255, 1'b0);
        queue_voxel(KIND_HIST, 8'd7, 8'd0, 1'b1);
        queue_voxel(KIND_FILTER, 8'd255, 8'd199, 1'b0);
        queue_voxel(KIND_FILTER, 8'd1, 8'd200, 1'b0);
        queue_voxel(KIND_FILTER, 8'd0, 8'd255, 1'b0);
        queue_voxel(KIND_FILTER, 8'd170, 8'd255, 1'b1);

        // Percentage above the scale, scan stopped by the depth limit at the first occupied bin.
        reconfigure(PCT_W'(127), MIN_W'(0));
        queue_voxel(KIND_HIST, 8'd3, 8'd5, 1'b1);
        queue_voxel(KIND_FILTER, 8'd85, 8'd4, 1'b0);
        queue_voxel(KIND_FILTER, 8'd170, 8'd5, 1'b1);

        reconfigure(PCT_W'(0), MIN_LARGEST);
        queue_voxel(KIND_HIST, 8'd0, 8'd0, 1'b1);
        queue_voxel(KIND_FILTER, 8'd255, 8'd255, 1'b1);
        volumes = 5;

        first_random = words_queued;
        while (words_queued < first_random + RANDOM_WORDS)
        begin
            while (pending_voxels.size() > 8)
            begin
                @(negedge clk);
            end
            if (words_queued > first_random + (RANDOM_WORDS * 4) / 5)
            begin
                gaps_on = 1'b0;
            end
            else
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pct_pick = '0;
                    1: pct_pick = PCT_SCALE;
                    2: pct_pick = '1;
                    default: pct_pick = PCT_W'($urandom_range(0, 127));
                endcase
                case ($urandom_range(0, 4))
                    0: min_pick = MIN_LARGEST;
                    1: min_pick = MIN_RESET;
                    2: min_pick = '0;
                    3: min_pick = MIN_W'(255);
                    default: min_pick = MIN_W'($urandom);
                endcase
                reconfigure(pct_pick, min_pick);
            end
            center = $urandom_range(0, 255);
            case ($urandom_range(0, 2))
                0: mask = 3;
                1: mask = 15;
                default: mask = 255;
            endcase
            plan = $urandom_range(0, 9);
            if (plan != 0)
            begin
                queue_pass(KIND_HIST, center, mask);
            end
            if (plan == 1)
            begin
                queue_pass(KIND_HIST, center, mask);
            end
            queue_pass(KIND_FILTER, center, mask);
            volumes++;
        end

        wait_quiet();
        if (expected_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_results.size()));
        end
        $display("Ran %0d volumes: %0d words in, %0d results checked, %0d register writes.",
                 volumes, words_taken, results_checked, cfg_writes);
        $display("Threshold scans: %0d, of which %0d selected no bin; %0d mismatches.",
                 scans_run, scans_empty, mismatches);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
